FILE: sv/pfr_pkg.sv
// Shared types and constants for the page frame replacement unit.
`timescale 1ns / 1ps

package pfr_pkg;

  localparam logic [1:0] POLICY_FIFO = 2'd0;
  localparam logic [1:0] POLICY_LFU  = 2'd1;
  localparam logic [1:0] POLICY_LRU  = 2'd2;

  localparam logic CFG_POLICY_MODE   = 1'b0;
  localparam logic CFG_FRAMES_IN_USE = 1'b1;

  localparam logic [4:0] FRAMES_RESET = 5'd16;

  typedef struct packed {
    logic [15:0] page_number;
    logic        last_of_run;
  } pfr_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame_index;
    logic [15:0] run_faults;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } pfr_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch accepted item
    logic start;   // restart frame sweep
    logic step;    // sweep one frame
    logic age;     // sweep writes LRU ages instead of searching
    logic commit;  // apply hit/miss updates
    logic emit;    // load output register
  } pfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_done;
    logic lru;
    logic out_valid;
  } pfr_stat_t;

endpackage

FILE: sv/pfr_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module pfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/pfr_ctrl.sv
// Sequencing state machine for the page frame replacement unit.
`timescale 1ns / 1ps

module pfr_ctrl
  import pfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_stall,
  input  pfr_stat_t stat,
  output pfr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_AGE    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.commit = 1'b1;
        cmd.start  = 1'b1;
        state_nxt  = stat.lru ? S_AGE : S_OUT;
      end
      S_AGE: begin
        cmd.step = 1'b1;
        cmd.age  = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register has room
        if (!(stat.out_valid && out_stall)) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: sv/pfr_dp.sv
// Datapath: frame tables, frame sweep, victim choice, counters and result register.
`timescale 1ns / 1ps

module pfr_dp
  import pfr_pkg::*;
#(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pfr_in_t    in_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic       out_stall,
  input  pfr_cmd_t   cmd,
  output pfr_stat_t  stat,
  output logic       out_valid,
  output pfr_out_t   out_data
);

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int N_W   = $clog2(NUM_FRAMES + 1);

  // configuration
  logic [1:0] mode_r;
  logic [4:0] frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= POLICY_FIFO;
      frames_r <= FRAMES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY_MODE:   mode_r   <= cfg_wdata[1:0];
        CFG_FRAMES_IN_USE: frames_r <= cfg_wdata;
        default:           mode_r   <= mode_r;
      endcase
    end
  end

  logic is_lfu, is_fifo;
  assign is_fifo = (mode_r == POLICY_FIFO);
  assign is_lfu  = (mode_r == POLICY_LFU);

  // active frame count, clamped to 1..NUM_FRAMES
  logic [31:0] n32;
  always_comb begin
    if (frames_r == 5'd0) begin
      n32 = 32'd1;
    end else if (32'(frames_r) > 32'(NUM_FRAMES)) begin
      n32 = 32'(NUM_FRAMES);
    end else begin
      n32 = 32'(frames_r);
    end
  end

  logic [N_W-1:0] n_act, n_last;
  assign n_act  = n32[N_W-1:0];
  assign n_last = n_act - N_W'(1);

  // accepted item
  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;
  logic [31:0]          page32;
  assign page32 = {16'd0, in_data.page_number};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= page32[PAGE_BITS-1:0];
      last_r <= in_data.last_of_run;
    end
  end

  // frame sweep: read address counter and read-data pipeline tag
  logic [N_W-1:0]   sweep_idx_r, sweep_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             issue;

  assign issue = cmd.step && (sweep_idx_r < n_act);

  always_comb begin
    sweep_idx_nxt = sweep_idx_r;
    if (cmd.start) begin
      sweep_idx_nxt = '0;
    end else if (issue) begin
      sweep_idx_nxt = sweep_idx_r + N_W'(1);
    end
    rd_vld_nxt = issue && !cmd.start;
    rd_idx_nxt = sweep_idx_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_idx_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      sweep_idx_r <= sweep_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
    rd_idx_r <= rd_idx_nxt;
  end

  logic sweep_done;
  assign sweep_done = rd_vld_r && ({{(N_W - IDX_W){1'b0}}, rd_idx_r} == n_last);

  // memories
  logic                  pg_we;
  logic [IDX_W-1:0]      pg_waddr;
  logic [PAGE_BITS-1:0]  pg_rdata;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;

  pfr_ram #(.WIDTH(PAGE_BITS), .DEPTH(NUM_FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (page_r),
    .raddr (sweep_idx_r[IDX_W-1:0]),
    .rdata (pg_rdata)
  );

  pfr_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_FRAMES)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (sweep_idx_r[IDX_W-1:0]),
    .rdata (cnt_rdata)
  );

  // count entries not yet written since reset read as zero
  logic [NUM_FRAMES-1:0] cnt_wr_r;
  logic [COUNT_BITS-1:0] cnt_val;
  assign cnt_val = cnt_wr_r[rd_idx_r] ? cnt_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_wr_r <= '0;
    end else if (cnt_we) begin
      cnt_wr_r[cnt_waddr] <= 1'b1;
    end
  end

  logic [NUM_FRAMES-1:0] valid_r, valid_nxt;

  // search results
  logic                  hit_r,   hit_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [COUNT_BITS-1:0] hit_cnt_r, hit_cnt_nxt;
  logic                  empty_r, empty_nxt;
  logic [IDX_W-1:0]      empty_idx_r, empty_idx_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [COUNT_BITS-1:0] best_cnt_r, best_cnt_nxt;

  logic scan_v, ent_valid, better;
  assign scan_v    = rd_vld_r && cmd.step && !cmd.age;
  assign ent_valid = valid_r[rd_idx_r];
  assign better    = is_lfu ? (cnt_val < best_cnt_r) : (cnt_val > best_cnt_r);

  always_comb begin
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    empty_nxt     = empty_r;
    empty_idx_nxt = empty_idx_r;
    best_idx_nxt  = best_idx_r;
    best_cnt_nxt  = best_cnt_r;
    if (cmd.load) begin
      hit_nxt   = 1'b0;
      empty_nxt = 1'b0;
    end else if (scan_v) begin
      if (!hit_r && ent_valid && (pg_rdata == page_r)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = rd_idx_r;
        hit_cnt_nxt = cnt_val;
      end
      if (!empty_r && !ent_valid) begin
        empty_nxt     = 1'b1;
        empty_idx_nxt = rd_idx_r;
      end
      // first frame seeds the min/max; ties keep the earlier frame
      if ((rd_idx_r == '0) || better) begin
        best_idx_nxt = rd_idx_r;
        best_cnt_nxt = cnt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      hit_r   <= hit_nxt;
      empty_r <= empty_nxt;
    end
    hit_idx_r   <= hit_idx_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    empty_idx_r <= empty_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cnt_r  <= best_cnt_nxt;
  end

  // victim and counters
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt, slot_sel;
  logic [15:0]      run_r, run_nxt;
  logic [31:0]      hit_tot_r, hit_tot_nxt;
  logic [31:0]      miss_tot_r, miss_tot_nxt;
  logic [31:0]      slot_inc;

  always_comb begin
    if (hit_r) begin
      slot_sel = hit_idx_r;
    end else if (empty_r) begin
      slot_sel = empty_idx_r;
    end else if (is_fifo) begin
      slot_sel = (32'(ptr_r) < n32) ? ptr_r : '0;
    end else begin
      slot_sel = best_idx_r;
    end
  end

  assign slot_inc = 32'(slot_sel) + 32'd1;

  logic [COUNT_BITS-1:0] age_val;
  assign age_val = (rd_idx_r == slot_r) ? '0 :
                   ((cnt_val == '1) ? cnt_val : cnt_val + COUNT_BITS'(1));

  always_comb begin
    ptr_nxt      = ptr_r;
    slot_nxt     = slot_r;
    run_nxt      = run_r;
    hit_tot_nxt  = hit_tot_r;
    miss_tot_nxt = miss_tot_r;
    valid_nxt    = valid_r;
    pg_we        = 1'b0;
    pg_waddr     = slot_sel;
    cnt_we       = 1'b0;
    cnt_waddr    = slot_sel;
    cnt_wdata    = COUNT_BITS'(1);
    if (cmd.commit) begin
      slot_nxt = slot_sel;
      if (hit_r) begin
        if (hit_tot_r != '1) begin
          hit_tot_nxt = hit_tot_r + 32'd1;
        end
        if (is_lfu) begin
          cnt_we    = 1'b1;
          cnt_wdata = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + COUNT_BITS'(1);
        end
      end else begin
        pg_we              = 1'b1;
        valid_nxt[slot_sel] = 1'b1;
        if (miss_tot_r != '1) begin
          miss_tot_nxt = miss_tot_r + 32'd1;
        end
        if (run_r != '1) begin
          run_nxt = run_r + 16'd1;
        end
        if (is_fifo) begin
          ptr_nxt = (slot_inc >= n32) ? '0 : slot_inc[IDX_W-1:0];
        end
        if (is_lfu) begin
          cnt_we = 1'b1;
        end
      end
    end else if (rd_vld_r && cmd.age) begin
      cnt_we    = 1'b1;
      cnt_waddr = rd_idx_r;
      cnt_wdata = age_val;
    end
    // end of run clears after the result has been captured
    if (cmd.emit && last_r) begin
      ptr_nxt = '0;
      run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      run_r      <= '0;
      hit_tot_r  <= '0;
      miss_tot_r <= '0;
      valid_r    <= '0;
    end else begin
      ptr_r      <= ptr_nxt;
      run_r      <= run_nxt;
      hit_tot_r  <= hit_tot_nxt;
      miss_tot_r <= miss_tot_nxt;
      valid_r    <= valid_nxt;
    end
    slot_r <= slot_nxt;
  end

  // result register
  logic        out_valid_r, out_valid_nxt;
  pfr_out_t    out_data_r;
  logic [31:0] slot32;
  assign slot32 = 32'(slot_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.emit) begin
      out_data_r.hit         <= hit_r;
      out_data_r.frame_index <= slot32[3:0];
      out_data_r.run_faults  <= run_r;
      out_data_r.hit_total   <= hit_tot_r;
      out_data_r.miss_total  <= miss_tot_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.sweep_done = sweep_done;
  assign stat.lru        = mode_r[1];
  assign stat.out_valid  = out_valid_r;

endmodule

FILE: sv/page_frame_replacement_unit.sv
// Top level of the page frame replacement unit.
`timescale 1ns / 1ps

// Fully associative page frame table with FIFO, LFU or LRU replacement. Each
// item is one page reference; the result tells hit or fault, the frame used,
// the faults of the current run and the saturating hit and miss totals. One
// search pass reads the page and count memories one frame a cycle, and LRU
// adds a second pass that rewrites every active frame's age through the
// single count write port. The next item is taken once the current one has
// reached the output register, even if that result is still waiting.
module page_frame_replacement_unit
  import pfr_pkg::*;
#(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pfr_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output pfr_out_t   out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata
);

  pfr_cmd_t  cmd;
  pfr_stat_t stat;

  pfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfr_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
